// ===== design/assert_macros.svh =====
// Assertion macros shared by the lock controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PDL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence on the same edge.
`define PDL_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/pdl_pkg.sv =====
// Shared types and constants of the password door lock controller.
`timescale 1ns / 1ps

package pdl_pkg;

   localparam int PASS_LEN = 5;
   localparam int IDX_W    = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
   localparam int TICK_W   = 20;
   localparam int ATT_W    = 4;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_ATTEMPTS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RUN_TICKS    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_TICKS   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ALARM_TICKS  = 8'd3;

   localparam logic [ATT_W-1:0]  RST_MAX_ATTEMPTS = 4'd3;
   localparam logic [TICK_W-1:0] RST_RUN_TICKS    = 20'd117187;
   localparam logic [TICK_W-1:0] RST_HOLD_TICKS   = 20'd23437;
   localparam logic [TICK_W-1:0] RST_ALARM_TICKS  = 20'd468750;

   localparam logic [7:0] CHAR_RETRY = 8'h78;   // 'x'
   localparam logic [7:0] CHAR_SETUP = 8'h2D;   // '-'
   localparam logic [7:0] CHAR_DOOR  = 8'h2B;   // '+'

   localparam logic [7:0] STATUS_FAIL = 8'd0;
   localparam logic [7:0] STATUS_PASS = 8'd1;

   localparam logic [1:0] MOTOR_STOP = 2'd0;
   localparam logic [1:0] MOTOR_CW   = 2'd1;
   localparam logic [1:0] MOTOR_CCW  = 2'd2;

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   typedef struct packed {
      logic [ATT_W-1:0]  max_attempts;
      logic [TICK_W-1:0] run_ticks;
      logic [TICK_W-1:0] hold_ticks;
      logic [TICK_W-1:0] alarm_ticks;
   } pdl_cfg_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [1:0] motor_drive;
      logic       alarm_on;
      logic       busy_res;
   } pdl_rsp_type;

endpackage

// ===== design/pdl_core.sv =====
// Lock controller state machine: one step per input beat, registered result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdl_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                action,
   input  logic [7:0]          rx_byte,
   input  pdl_pkg::pdl_cfg_type cfg,
   output pdl_pkg::pdl_rsp_type result
);
   import pdl_pkg::*;

   typedef enum logic [3:0] {
      M_SETUP1, M_SETUP2, M_OPTION, M_CHECK, M_WAITX,
      M_CW, M_HOLD, M_CCW, M_ALARM
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [IDX_W-1:0]  byte_idx_ff, byte_idx_in;
   logic [ATT_W-1:0]  attempt_ff, attempt_in;
   logic [7:0]        first_ff [PASS_LEN];
   logic [7:0]        first_in [PASS_LEN];
   logic [7:0]        stored_ff [PASS_LEN];
   logic [7:0]        stored_in [PASS_LEN];
   logic              all_matched_ff, all_matched_in;
   logic [7:0]        option_ff, option_in;
   logic [TICK_W-1:0] phase_ff, phase_in;
   pdl_rsp_type       result_ff, result_in;

   logic              last;
   logic              enter;
   mode_type          enter_mode;
   logic [TICK_W-1:0] phase_next;
   logic [TICK_W-1:0] limit;
   logic [ATT_W-1:0]  attempt_next;

   assign last         = (byte_idx_ff == IDX_W'(PASS_LEN - 1));
   assign phase_next   = phase_ff + 1'b1;
   assign attempt_next = attempt_ff + 1'b1;

   always_comb begin
      case (mode_ff)
         M_HOLD:  limit = cfg.hold_ticks;
         M_ALARM: limit = cfg.alarm_ticks;
         default: limit = cfg.run_ticks;
      endcase
   end

   always_comb begin
      mode_in        = mode_ff;
      byte_idx_in    = byte_idx_ff;
      attempt_in     = attempt_ff;
      first_in       = first_ff;
      stored_in      = stored_ff;
      all_matched_in = all_matched_ff;
      option_in      = option_ff;
      phase_in       = phase_ff;
      enter          = 1'b0;
      enter_mode     = mode_ff;
      result_in      = '0;

      if (action == ACTION_TICK) begin
         unique case (mode_ff) inside
            M_CW, M_HOLD, M_CCW, M_ALARM: begin
               phase_in = phase_next;
               if (phase_next >= limit) begin
                  enter = 1'b1;
                  unique case (mode_ff)
                     M_CW:    enter_mode = M_HOLD;
                     M_HOLD:  enter_mode = M_CCW;
                     default: enter_mode = M_OPTION;
                  endcase
                  if (mode_ff == M_ALARM) begin
                     attempt_in = '0;
                  end
               end
            end
            default: ;
         endcase
      end else begin
         unique case (mode_ff)
            M_SETUP1: begin
               first_in[byte_idx_ff] = rx_byte;
               if (last) begin
                  enter      = 1'b1;
                  enter_mode = M_SETUP2;
               end else begin
                  byte_idx_in = byte_idx_ff + 1'b1;
               end
            end
            M_SETUP2: begin
               all_matched_in = all_matched_ff && (first_ff[byte_idx_ff] == rx_byte);
               if (last) begin
                  result_in.tx_valid = 1'b1;
                  enter              = 1'b1;
                  if (all_matched_in) begin
                     stored_in         = first_ff;
                     result_in.tx_byte = STATUS_PASS;
                     enter_mode        = M_OPTION;
                  end else begin
                     result_in.tx_byte = STATUS_FAIL;
                     enter_mode        = M_SETUP1;
                  end
               end else begin
                  byte_idx_in = byte_idx_ff + 1'b1;
               end
            end
            M_OPTION: begin
               option_in  = rx_byte;
               attempt_in = '0;
               enter      = 1'b1;
               enter_mode = M_CHECK;
            end
            M_CHECK: begin
               all_matched_in = all_matched_ff && (stored_ff[byte_idx_ff] == rx_byte);
               if (last) begin
                  result_in.tx_valid = 1'b1;
                  enter              = 1'b1;
                  if (all_matched_in) begin
                     result_in.tx_byte = STATUS_PASS;
                     if (option_ff == CHAR_SETUP) begin
                        enter_mode = M_SETUP1;
                     end else if (option_ff == CHAR_DOOR) begin
                        enter_mode = M_CW;
                     end else begin
                        enter_mode = M_OPTION;
                     end
                  end else begin
                     result_in.tx_byte = STATUS_FAIL;
                     enter_mode        = M_WAITX;
                  end
               end else begin
                  byte_idx_in = byte_idx_ff + 1'b1;
               end
            end
            M_WAITX: begin
               if (rx_byte == CHAR_RETRY) begin
                  attempt_in = attempt_next;
                  enter      = 1'b1;
                  enter_mode = (attempt_next >= cfg.max_attempts) ? M_ALARM : M_CHECK;
               end
            end
            default: ;
         endcase
      end

      // Entering a mode restarts the entry and phase bookkeeping.
      if (enter) begin
         mode_in        = enter_mode;
         byte_idx_in    = '0;
         all_matched_in = 1'b1;
         phase_in       = '0;
      end

      result_in.motor_drive = (mode_in == M_CW)  ? MOTOR_CW :
                              (mode_in == M_CCW) ? MOTOR_CCW : MOTOR_STOP;
      result_in.alarm_on    = (mode_in == M_ALARM);
      result_in.busy_res    = (mode_in == M_CW) || (mode_in == M_HOLD) ||
                              (mode_in == M_CCW) || (mode_in == M_ALARM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= M_SETUP1;
         byte_idx_ff    <= '0;
         attempt_ff     <= '0;
         all_matched_ff <= 1'b1;
         option_ff      <= '0;
         phase_ff       <= '0;
      end else if (step_en) begin
         mode_ff        <= mode_in;
         byte_idx_ff    <= byte_idx_in;
         attempt_ff     <= attempt_in;
         all_matched_ff <= all_matched_in;
         option_ff      <= option_in;
         phase_ff       <= phase_in;
         first_ff       <= first_in;
         stored_ff      <= stored_in;
         result_ff      <= result_in;
      end
   end

   assign result = result_ff;

   `PDL_ASSERT_IMPL(a_idx_only_in_entry, clock, reset,
      (mode_ff != M_SETUP1) && (mode_ff != M_SETUP2) && (mode_ff != M_CHECK),
      byte_idx_ff == '0, "byte index moved outside a password entry")
   `PDL_ASSERT(a_option_to_check, clock, reset,
      (step_en && action == ACTION_BYTE && mode_ff == M_OPTION) |=> (mode_ff == M_CHECK),
      "option byte did not lead to the entry check")
   `PDL_ASSERT(a_idx_in_range, clock, reset,
      (step_en && last) |=> (byte_idx_ff == '0 || $past(action) == ACTION_TICK),
      "byte index ran past the last password byte")

endmodule

// ===== design/password_door_lock_controller.sv =====
// Top level of the password door lock controller: handshakes, registers, core.
//
// Usage:
//   req_* carries one item per beat: req_action 0 is a received link byte in
//   req_rx_byte, req_action 1 is one timer tick. Every accepted item gives
//   exactly one rsp_* beat: the status byte to send (rsp_tx_valid and
//   rsp_tx_byte), and the motor, alarm and busy state after the item.
//   csr_* writes one of four registers by index: 0 max_attempts,
//   1 run_ticks, 2 hold_ticks, 3 alarm_ticks; other indexes are dropped.
//   csr_ready is always high; write only while no item is in flight.
// Timing:
//   An item is taken into the input register on acceptance and stepped into the
//   result register once the output can advance; rsp_valid rises with that step.
//   One item per cycle is sustained while rsp_ready stays high; the rate is set
//   by the controller core, which updates its whole state in one step per item.
// Reset and stall:
//   Reset returns to the first setup password and restores the register
//   defaults; the password stores hold no defined value until written.
//   When rsp_ready is low the result holds and one more item waits in the
//   input register; after that req_ready drops until the result is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module password_door_lock_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_tx_valid,
   output logic [7:0]                    rsp_tx_byte,
   output logic [1:0]                    rsp_motor_drive,
   output logic                          rsp_alarm_on,
   output logic                          rsp_busy_res,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pdl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdl_pkg::TICK_W-1:0]    csr_data
);
   import pdl_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic        in_action_ff;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   pdl_cfg_type cfg_ff, cfg_in;
   pdl_rsp_type result;
   logic        advance;
   logic        step_en;
   logic        req_fire;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_fire ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step_en ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MAX_ATTEMPTS: cfg_in.max_attempts = csr_data[ATT_W-1:0];
            REG_RUN_TICKS:    cfg_in.run_ticks    = csr_data;
            REG_HOLD_TICKS:   cfg_in.hold_ticks   = csr_data;
            REG_ALARM_TICKS:  cfg_in.alarm_ticks  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         cfg_ff.max_attempts <= RST_MAX_ATTEMPTS;
         cfg_ff.run_ticks    <= RST_RUN_TICKS;
         cfg_ff.hold_ticks   <= RST_HOLD_TICKS;
         cfg_ff.alarm_ticks  <= RST_ALARM_TICKS;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_rx_byte;
      end
   end

   pdl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .action  (in_action_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_valid    = result.tx_valid;
   assign rsp_tx_byte     = result.tx_byte;
   assign rsp_motor_drive = result.motor_drive;
   assign rsp_alarm_on    = result.alarm_on;
   assign rsp_busy_res    = result.busy_res;

   `PDL_ASSERT_IMPL(a_quiet_status, clock, reset,
      rsp_valid_ff && !rsp_tx_valid, rsp_tx_byte == STATUS_FAIL,
      "status byte set without a status beat")
   `PDL_ASSERT_IMPL(a_busy_covers_actuators, clock, reset,
      rsp_valid_ff && (rsp_alarm_on || rsp_motor_drive != MOTOR_STOP),
      rsp_busy_res && !(rsp_alarm_on && rsp_motor_drive != MOTOR_STOP),
      "motor or alarm active outside a busy sequence")
   `PDL_ASSERT(a_step_gives_beat, clock, reset,
      step_en |=> rsp_valid_ff, "stepped item produced no result beat")

endmodule

// ===== dv/password_door_lock_controller_tb.sv =====
// Self-checking testbench of the password door lock controller with a built-in lock predictor.
`timescale 1ns / 1ps

module password_door_lock_controller_tb;
   import pdl_pkg::*;

   localparam int LIMIT_CYCLES = 300000;
   localparam int IDLE_SETTLE  = 4;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 8'd4;
   localparam logic [TICK_W-1:0]    TICK_MAX     = 20'hFFFFF;

   typedef enum logic [3:0] {
      MODE_SETUP1, MODE_SETUP2, MODE_OPTION, MODE_CHECK, MODE_WAITX,
      MODE_CW, MODE_HOLD, MODE_CCW, MODE_ALARM
   } lock_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_action = ACTION_BYTE;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_tx_valid;
   logic [7:0]           rsp_tx_byte;
   logic [1:0]           rsp_motor_drive;
   logic                 rsp_alarm_on;
   logic                 rsp_busy_res;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TICK_W-1:0]    csr_data = '0;

   // Predicted lock state and register copy.
   pdl_cfg_type          lk_cfg;
   lock_mode_type        lk_mode;
   logic [IDX_W-1:0]     lk_idx;
   logic [ATT_W-1:0]     lk_attempts;
   logic [7:0]           lk_store [PASS_LEN];
   logic [7:0]           lk_first [PASS_LEN];
   bit                   lk_match;
   logic [7:0]           lk_option;
   logic [TICK_W-1:0]    lk_ticks;

   pdl_rsp_type          expected_status_q [$];
   int                   mismatch_count = 0;
   int                   cycle_count = 0;
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   int                   rsp_hold_req = 0;
   int                   rsp_hold_left = 0;
   bit                   entry_good = 1'b1;
   int                   bad_pos = 0;

   password_door_lock_controller u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_motor_drive (rsp_motor_drive),
      .rsp_alarm_on    (rsp_alarm_on),
      .rsp_busy_res    (rsp_busy_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void lock_enter(input lock_mode_type m);
      lk_mode  = m;
      lk_idx   = '0;
      lk_match = 1'b1;
      lk_ticks = '0;
   endfunction

   function automatic void lock_reset();
      lk_cfg.max_attempts = RST_MAX_ATTEMPTS;
      lk_cfg.run_ticks    = RST_RUN_TICKS;
      lk_cfg.hold_ticks   = RST_HOLD_TICKS;
      lk_cfg.alarm_ticks  = RST_ALARM_TICKS;
      for (int k = 0; k < PASS_LEN; k++) begin
         lk_store[k] = 8'h00;
         lk_first[k] = 8'h00;
      end
      lk_attempts = '0;
      lk_option   = 8'h00;
      lock_enter(MODE_SETUP1);
   endfunction

   // Counts one tick of the running phase and tells whether the phase is over.
   function automatic bit phase_over(input logic [TICK_W-1:0] limit);
      lk_ticks = lk_ticks + 1'b1;
      return (lk_ticks >= limit);
   endfunction

   // An item counts as stimulus only when the lock does not simply drop it.
   function automatic bit item_counts(input logic act, input logic [7:0] b);
      bit running;
      running = (lk_mode >= MODE_CW) && (lk_mode <= MODE_ALARM);
      if (act == ACTION_TICK) return running;
      if (running) return 1'b0;
      return !(lk_mode == MODE_WAITX && b != CHAR_RETRY);
   endfunction

   function automatic void predict_status(input logic act, input logic [7:0] b);
      pdl_rsp_type r;
      int          i;
      bit          last;
      r = '0;
      i = int'(lk_idx);
      if (i >= PASS_LEN) i = PASS_LEN - 1;
      last = (i + 1) >= PASS_LEN;
      if (act == ACTION_TICK) begin
         case (lk_mode)
            MODE_CW:   if (phase_over(lk_cfg.run_ticks)) lock_enter(MODE_HOLD);
            MODE_HOLD: if (phase_over(lk_cfg.hold_ticks)) lock_enter(MODE_CCW);
            MODE_CCW:  if (phase_over(lk_cfg.run_ticks)) lock_enter(MODE_OPTION);
            MODE_ALARM: begin
               if (phase_over(lk_cfg.alarm_ticks)) begin
                  lk_attempts = '0;
                  lock_enter(MODE_OPTION);
               end
            end
            default: ;
         endcase
      end else begin
         case (lk_mode)
            MODE_SETUP1: begin
               lk_first[i] = b;
               if (last) lock_enter(MODE_SETUP2);
               else lk_idx = IDX_W'(i + 1);
            end
            MODE_SETUP2: begin
               if (lk_first[i] != b) lk_match = 1'b0;
               if (last) begin
                  r.tx_valid = 1'b1;
                  if (lk_match) begin
                     for (int k = 0; k < PASS_LEN; k++) lk_store[k] = lk_first[k];
                     r.tx_byte = STATUS_PASS;
                     lock_enter(MODE_OPTION);
                  end else begin
                     r.tx_byte = STATUS_FAIL;
                     lock_enter(MODE_SETUP1);
                  end
               end else begin
                  lk_idx = IDX_W'(i + 1);
               end
            end
            MODE_OPTION: begin
               lk_option   = b;
               lk_attempts = '0;
               lock_enter(MODE_CHECK);
            end
            MODE_CHECK: begin
               if (lk_store[i] != b) lk_match = 1'b0;
               if (last) begin
                  r.tx_valid = 1'b1;
                  if (lk_match) begin
                     r.tx_byte = STATUS_PASS;
                     if (lk_option == CHAR_SETUP) lock_enter(MODE_SETUP1);
                     else if (lk_option == CHAR_DOOR) lock_enter(MODE_CW);
                     else lock_enter(MODE_OPTION);
                  end else begin
                     r.tx_byte = STATUS_FAIL;
                     lock_enter(MODE_WAITX);
                  end
               end else begin
                  lk_idx = IDX_W'(i + 1);
               end
            end
            MODE_WAITX: begin
               if (b == CHAR_RETRY) begin
                  lk_attempts = lk_attempts + 1'b1;
                  if (lk_attempts >= lk_cfg.max_attempts) lock_enter(MODE_ALARM);
                  else lock_enter(MODE_CHECK);
               end
            end
            default: ;
         endcase
      end
      r.motor_drive = (lk_mode == MODE_CW)  ? MOTOR_CW :
                      (lk_mode == MODE_CCW) ? MOTOR_CCW : MOTOR_STOP;
      r.alarm_on    = (lk_mode == MODE_ALARM);
      r.busy_res    = (lk_mode >= MODE_CW) && (lk_mode <= MODE_ALARM);
      expected_status_q.push_back(r);
   endfunction

   // Offers one item, holds it until the beat, then predicts its status.
   task automatic send_item(input logic act, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_status(act, b);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_MAX_ATTEMPTS: lk_cfg.max_attempts = data[ATT_W-1:0];
         REG_RUN_TICKS:    lk_cfg.run_ticks    = data;
         REG_HOLD_TICKS:   lk_cfg.hold_ticks   = data;
         REG_ALARM_TICKS:  lk_cfg.alarm_ticks  = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [TICK_W-1:0] attempts, input logic [TICK_W-1:0] run,
                             input logic [TICK_W-1:0] hold, input logic [TICK_W-1:0] alarm);
      wait_idle();
      write_reg(REG_MAX_ATTEMPTS, attempts);
      write_reg(REG_RUN_TICKS, run);
      write_reg(REG_HOLD_TICKS, hold);
      write_reg(REG_ALARM_TICKS, alarm);
   endtask

   function automatic logic [7:0] entry_byte(input logic [7:0] right);
      if (lk_idx == 0) begin
         entry_good = ($urandom_range(99) < 70);
         bad_pos    = int'($urandom_range(PASS_LEN - 1));
      end
      if (!entry_good && int'(lk_idx) == bad_pos) return right ^ 8'($urandom_range(255, 1));
      return right;
   endfunction

   // Mostly well-formed sessions steered by the predicted mode, with some noise.
   task automatic pick_item(output logic act, output logic [7:0] b);
      int unsigned roll;
      roll = $urandom_range(99);
      act  = ACTION_BYTE;
      b    = 8'($urandom);
      if (roll < 5) begin
         act = 1'($urandom_range(1));
         return;
      end
      roll = $urandom_range(99);
      case (lk_mode) inside
         MODE_SETUP2: b = entry_byte(lk_first[lk_idx]);
         MODE_CHECK:  b = entry_byte(lk_store[lk_idx]);
         MODE_OPTION: begin
            if (roll < 40) b = CHAR_DOOR;
            else if (roll < 55) b = CHAR_SETUP;
         end
         MODE_WAITX: begin
            if (roll < 35) b = CHAR_RETRY;
            else if (roll < 45) act = ACTION_TICK;
         end
         MODE_CW, MODE_HOLD, MODE_CCW, MODE_ALARM: if (roll < 88) act = ACTION_TICK;
         default: ;
      endcase
   endtask

   task automatic run_random(input int n_items, input int idle_pct, input int stall_in);
      int         done;
      logic       act;
      logic [7:0] b;
      send_idle_pct = idle_pct;
      stall_pct     = stall_in;
      done          = 0;
      while (done < n_items) begin
         pick_item(act, b);
         if (item_counts(act, b)) done++;
         send_item(act, b);
      end
   endtask

   task automatic send_password(input bit good);
      for (int k = 0; k < PASS_LEN; k++)
         send_item(ACTION_BYTE, (good || k != 0) ? lk_store[k] : ~lk_store[k]);
   endtask

   // Tick outside a running phase, a setup pair that differs in the first byte, then a good setup.
   task automatic test_setup();
      logic [7:0] pw [PASS_LEN];
      pw = '{8'h00, 8'hFF, CHAR_DOOR, CHAR_SETUP, CHAR_RETRY};
      send_item(ACTION_TICK, 8'hA5);
      for (int k = 0; k < PASS_LEN; k++) send_item(ACTION_BYTE, pw[k]);
      for (int k = 0; k < PASS_LEN; k++) send_item(ACTION_BYTE, (k == 0) ? ~pw[k] : pw[k]);
      for (int k = 0; k < PASS_LEN; k++) send_item(ACTION_BYTE, pw[k]);
      for (int k = 0; k < PASS_LEN; k++) send_item(ACTION_BYTE, pw[k]);
   endtask

   // Longest phase lengths: the CW, hold and alarm phases start at the maximum and are cut short by a rewrite.
   task automatic test_long_phases();
      set_config(TICK_W'(RST_MAX_ATTEMPTS), TICK_MAX, TICK_MAX, TICK_MAX);
      write_reg(REG_UNMAPPED, TICK_MAX);
      // Upper data bits are dropped by the 4-bit attempts register.
      write_reg(REG_MAX_ATTEMPTS, 20'hFFFF1);
      send_item(ACTION_BYTE, CHAR_DOOR);
      send_password(1'b1);
      repeat (3) send_item(ACTION_TICK, 8'h00);
      send_item(ACTION_BYTE, CHAR_RETRY);
      wait_idle();
      write_reg(REG_RUN_TICKS, 20'd1);
      repeat (3) send_item(ACTION_TICK, 8'hFF);
      wait_idle();
      write_reg(REG_HOLD_TICKS, 20'd1);
      repeat (2) send_item(ACTION_TICK, 8'h00);
      send_item(ACTION_BYTE, 8'h41);
      send_password(1'b0);
      send_item(ACTION_BYTE, 8'h79);
      send_item(ACTION_TICK, 8'h00);
      send_item(ACTION_BYTE, CHAR_RETRY);
      repeat (2) send_item(ACTION_TICK, 8'h00);
      send_item(ACTION_BYTE, CHAR_DOOR);
      wait_idle();
      write_reg(REG_ALARM_TICKS, 20'd1);
      send_item(ACTION_TICK, 8'h00);
   endtask

   task automatic test_random_phases();
      set_config(20'd3, 20'd4, 20'd2, 20'd5);
      run_random(200, 0, 0);
      set_config(20'd1, 20'd1, 20'd1, 20'd1);
      run_random(200, 80, 0);
      set_config(20'd15, TICK_W'($urandom_range(12, 1)), TICK_W'($urandom_range(12, 1)),
                 TICK_W'($urandom_range(12, 1)));
      run_random(200, 0, 80);
      // Zero registers lie outside the range: a phase then ends after one tick.
      set_config(20'd0, 20'd0, TICK_W'($urandom_range(12, 1)), 20'd0);
      run_random(150, 26, 26);
      set_config(TICK_W'($urandom_range(15, 1)), TICK_W'($urandom_range(12, 1)),
                 TICK_W'($urandom_range(12, 1)), TICK_W'($urandom_range(12, 1)));
      run_random(150, 26, 26);
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      wait_idle();
      rsp_hold_req = 300;
      run_random(40, 0, 0);
   endtask

   always @(posedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req  = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_status
      pdl_rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status_q.size() == 0) begin
            $display("%0t: status beat with none expected, expected none, actual %0d/%0d",
                     $time, rsp_tx_valid, rsp_tx_byte);
            mismatch_count++;
         end else begin
            exp_r = expected_status_q.pop_front();
            check_field("tx_valid", 8'(exp_r.tx_valid), 8'(rsp_tx_valid));
            check_field("tx_byte", exp_r.tx_byte, rsp_tx_byte);
            check_field("motor_drive", 8'(exp_r.motor_drive), 8'(rsp_motor_drive));
            check_field("alarm_on", 8'(exp_r.alarm_on), 8'(rsp_alarm_on));
            check_field("busy_res", 8'(exp_r.busy_res), 8'(rsp_busy_res));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d statuses outstanding", $time, expected_status_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      lock_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_setup();
      test_long_phases();
      test_random_phases();
      test_backpressure();
      wait_idle();
      if (expected_status_q.size() != 0) mismatch_count++;
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/pdl_pkg.sv
design/pdl_core.sv
design/password_door_lock_controller.sv
dv/password_door_lock_controller_tb.sv
